[rtl/core/karplus_strong_drum_voice_assert.svh]
// Assertion macros for the drum voice core.
// Depends on nothing; included by the top level before its module header.
`ifndef KARPLUS_STRONG_DRUM_VOICE_ASSERT_SVH
`define KARPLUS_STRONG_DRUM_VOICE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define KSDV_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KSDV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ksdv_pkg.sv]
// Shared types, constants and helpers for the drum voice core.
// No dependencies; compiled first.
package ksdv_pkg;

    localparam int GAIN_W     = 16;
    localparam int PCT_W      = 7;
    localparam int PLEN_W     = 11;
    localparam int SEED_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DECAY_GAIN    = 3'd0;
    localparam t_cfg_idx REG_PLUS_PERCENT  = 3'd1;
    localparam t_cfg_idx REG_PERIOD_LENGTH = 3'd2;
    localparam t_cfg_idx REG_NOISE_SEED    = 3'd3;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 16'd32768;
    localparam logic [PCT_W-1:0]  PCT_RESET   = 7'd50;
    localparam logic [PLEN_W-1:0] PLEN_RESET  = 11'd100;
    localparam logic [PLEN_W-1:0] PLEN_MIN    = 11'd2;
    localparam logic [SEED_W-1:0] SEED_RESET  = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;

    // Draw mod 100 by reciprocal: q = (x * 41943) >> 22 is exact or one low.
    localparam int DRAW_MOD    = 100;
    localparam int RECIP_MULT  = 41943;
    localparam int RECIP_SHIFT = 22;
    localparam int QUOT_W      = 10;
    localparam int REM_W       = 8;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        logic step;       // sample item transferred: advance the LFSR
        logic advance;    // stage 1 moves to stage 2
        logic seed_load;  // seed register written
    } t_sign_ctl;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

    function automatic logic [SEED_W-1:0] seed_fix(input logic [SEED_W-1:0] s);
        return (s == '0) ? SEED_W'(1) : s;
    endfunction

endpackage

[rtl/core/ksdv_if.sv]
// Valid/ready channel interfaces for the drum voice core.
// Depends on nothing; the payload width is a parameter.
interface ksdv_in_if #(parameter int SAMPLE_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic signed [SAMPLE_WIDTH-1:0] load_value;

    modport source (output valid, output op, output load_value, input ready);
    modport sink   (input valid, input op, input load_value, output ready);
endinterface

interface ksdv_out_if #(parameter int SAMPLE_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/core/ksdv_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ksdv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ksdv_sign.sv]
// Sign draw: 16-bit Galois LFSR and a pipelined mod-100 compare.
// Depends on ksdv_pkg.
module ksdv_sign import ksdv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sign_ctl         i_ctl,
    input  logic [SEED_W-1:0] i_seed,
    input  logic [PCT_W-1:0]  i_plus_percent,
    output logic              o_positive
);

    logic [SEED_W-1:0] r_lfsr;
    logic [SEED_W-1:0] n_lfsr;
    logic [SEED_W-1:0] r_draw;
    logic [SEED_W-1:0] r_draw_s2;
    logic [QUOT_W-1:0] r_quot;
    logic [31:0]       quot_prod;
    logic [16:0]       rem_diff;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem_fix;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_ctl.seed_load) begin
            n_lfsr = seed_fix(i_seed);
        end else if (i_ctl.step) begin
            n_lfsr = lfsr_step(r_lfsr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign quot_prod = 32'(r_draw) * 32'(RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_draw <= n_lfsr;
        end
        if (i_ctl.advance) begin
            r_draw_s2 <= r_draw;
            r_quot    <= QUOT_W'(quot_prod >> RECIP_SHIFT);
        end
    end

    // Remainder lands in [0, 199]; one conditional subtract fixes it.
    assign rem_diff = 17'(r_draw_s2) - 17'(r_quot) * 17'(DRAW_MOD);
    assign rem_raw  = rem_diff[REM_W-1:0];
    assign rem_fix  = (rem_raw >= REM_W'(DRAW_MOD)) ? (rem_raw - REM_W'(DRAW_MOD)) : rem_raw;

    assign o_positive = rem_fix < REM_W'(i_plus_percent);

endmodule

[rtl/core/ksdv_mac.sv]
// Averaging, gain multiply, rounding, sign and saturation of one sample.
// Depends on ksdv_pkg.
module ksdv_mac import ksdv_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0] i_entry,
    input  logic signed [SAMPLE_WIDTH-1:0] i_prev,
    input  logic [GAIN_W-1:0]              i_gain,
    input  logic                           i_positive,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int SUM_W  = SAMPLE_WIDTH + 1;
    localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 2;
    localparam int VAL_W  = PROD_W - 16;
    localparam int NEG_W  = VAL_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);
    localparam logic signed [NEG_W-1:0]  SAT_HI =
        NEG_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [NEG_W-1:0]  SAT_LO = -SAT_HI - NEG_W'(1);

    logic [GAIN_W-1:0]        gain_c;
    logic signed [SUM_W-1:0]  sum;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [VAL_W-1:0]  rounded;
    logic signed [NEG_W-1:0]  rounded_x;
    logic signed [NEG_W-1:0]  val;

    assign gain_c = (i_gain > GAIN_ONE) ? GAIN_ONE : i_gain;
    assign sum    = {i_entry[SAMPLE_WIDTH-1], i_entry} + {i_prev[SAMPLE_WIDTH-1], i_prev};
    assign gain_s = {1'b0, gain_c};
    assign prod_c = sum * gain_s;

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod <= prod_c;
        end
    end

    // Round half up: add one half, keep the high bits (floor).
    assign biased    = r_prod + ROUND_BIAS;
    assign rounded   = biased[PROD_W-1:16];
    assign rounded_x = {rounded[VAL_W-1], rounded};
    assign val       = i_positive ? rounded_x : -rounded_x;

    always_comb begin
        priority if (val > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (val < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = val[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

[rtl/core/karplus_strong_drum_voice.sv]
// Karplus-Strong drum voice. A sample result passes the stage 1 and stage 2 registers
// before it sits in the output register. A new item is taken only once the one before has
// left stage 1, a limit set by the previous-sample loop (RAM read, gain multiply, round and write-back).
// Reset (synchronous, active low) clears positions, previous sample, pipeline valids
// and the output valid, and loads register defaults and the LFSR seed. The wavetable RAM
// is not cleared: no clearing pass, entries are undefined until loaded.
`include "karplus_strong_drum_voice_assert.svh"

module karplus_strong_drum_voice import ksdv_pkg::*; #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ksdv_in_if.sink               i_item,
    ksdv_out_if.source            o_result
);

    localparam int POS_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = POS_W + 1;
    localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] r_decay_gain;
    logic [PCT_W-1:0]  r_plus_percent;
    logic [PLEN_W-1:0] r_period_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_gain    <= GAIN_ONE;
            r_plus_percent  <= PCT_RESET;
            r_period_length <= PLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DECAY_GAIN:    r_decay_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_PLUS_PERCENT:  r_plus_percent  <= i_cfg_data[PCT_W-1:0];
                REG_PERIOD_LENGTH: r_period_length <= i_cfg_data[PLEN_W-1:0];
                default: ;  // seed goes to the LFSR; other indexes are ignored
            endcase
        end
    end

    // Effective ring length, clamped to [2, TABLE_DEPTH].
    logic [CMP_W-1:0] plen_x;
    logic [CMP_W-1:0] len_c;
    logic [LEN_W-1:0] len_eff;

    assign plen_x = CMP_W'(r_period_length);

    always_comb begin
        priority if (plen_x < CMP_W'(PLEN_MIN)) begin
            len_c = CMP_W'(PLEN_MIN);
        end else if (plen_x > CMP_W'(TABLE_DEPTH)) begin
            len_c = CMP_W'(TABLE_DEPTH);
        end else begin
            len_c = plen_x;
        end
    end

    assign len_eff = len_c[LEN_W-1:0];

    // ---------------- pipeline control ----------------
    // Stage 0: transfer, position update, RAM read issued.
    // Stage 1: read data (or forwarded write) + previous sample, multiply.
    // Stage 2: round/sign/saturate, write back, update previous, fill output.
    logic                           in_ready;
    logic                           in_xfer;
    logic                           in_sample;
    logic                           s2_go;

    logic                           r_s1_valid;
    t_op                            r_s1_op;
    logic [POS_W-1:0]               r_s1_addr;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_load;

    logic                           r_s2_valid;
    t_op                            r_s2_op;
    logic [POS_W-1:0]               r_s2_addr;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_load;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;

    // Stage 2 only waits when a sample has nowhere to go.
    assign s2_go    = r_s2_valid &&
                      ((r_s2_op == OP_LOAD) || !r_out_valid || o_result.ready);
    // One item in flight ahead of stage 2; stage 1 therefore never stalls.
    assign in_ready = !r_s1_valid && (!r_s2_valid || s2_go);
    assign in_xfer  = i_item.valid && in_ready;
    assign in_sample = (i_item.op == OP_SAMPLE);

    assign i_item.ready = in_ready;

    // ---------------- ring positions ----------------
    logic [POS_W-1:0] r_read_pos;
    logic [POS_W-1:0] r_load_pos;
    logic [POS_W-1:0] n_read_pos;
    logic [POS_W-1:0] n_load_pos;
    logic [POS_W-1:0] read_cur;
    logic [POS_W-1:0] load_cur;
    logic [LEN_W-1:0] read_inc;
    logic [LEN_W-1:0] load_inc;
    logic [POS_W-1:0] acc_addr;

    // A position left past the end by a shorter ring restarts at zero.
    assign read_cur = ({1'b0, r_read_pos} >= len_eff) ? '0 : r_read_pos;
    assign load_cur = ({1'b0, r_load_pos} >= len_eff) ? '0 : r_load_pos;
    assign read_inc = {1'b0, read_cur} + LEN_W'(1);
    assign load_inc = {1'b0, load_cur} + LEN_W'(1);
    assign acc_addr = in_sample ? read_cur : load_cur;

    always_comb begin
        n_read_pos = r_read_pos;
        n_load_pos = r_load_pos;
        if (in_xfer) begin
            if (in_sample) begin
                n_read_pos = (read_inc >= len_eff) ? '0 : read_inc[POS_W-1:0];
            end else begin
                n_load_pos = (load_inc >= len_eff) ? '0 : load_inc[POS_W-1:0];
                n_read_pos = '0;
            end
        end
    end

    // ---------------- wavetable RAM and forwarding ----------------
    logic signed [SAMPLE_WIDTH-1:0] s2_result;
    logic signed [SAMPLE_WIDTH-1:0] wb_data;
    logic [SAMPLE_WIDTH-1:0]        ram_rdata;
    logic                           r_fwd_hit;
    logic signed [SAMPLE_WIDTH-1:0] r_fwd_data;
    logic signed [SAMPLE_WIDTH-1:0] s1_entry;

    assign wb_data = (r_s2_op == OP_SAMPLE) ? s2_result : r_s2_load;

    ksdv_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s2_go),
        .i_waddr (r_s2_addr),
        .i_wdata (wb_data),
        .i_re    (in_xfer),
        .i_raddr (acc_addr),
        .o_rdata (ram_rdata)
    );

    // A read issued in the cycle the same entry is written takes the new value.
    assign s1_entry = r_fwd_hit ? r_fwd_data : $signed(ram_rdata);

    // ---------------- previous sample ----------------
    logic signed [SAMPLE_WIDTH-1:0] r_prev;

    // ---------------- sign draw and arithmetic ----------------
    t_sign_ctl sign_ctl;
    logic      s2_positive;

    assign sign_ctl.step      = in_xfer && in_sample;
    assign sign_ctl.advance   = r_s1_valid;
    assign sign_ctl.seed_load = i_cfg_we && (i_cfg_index == REG_NOISE_SEED);

    ksdv_sign u_sign (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (sign_ctl),
        .i_seed         (i_cfg_data[SEED_W-1:0]),
        .i_plus_percent (r_plus_percent),
        .o_positive     (s2_positive)
    );

    ksdv_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk      (i_clk),
        .i_advance  (r_s1_valid),
        .i_entry    (s1_entry),
        .i_prev     (r_prev),
        .i_gain     (r_decay_gain),
        .i_positive (s2_positive),
        .o_result   (s2_result)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pos  <= '0;
            r_load_pos  <= '0;
            r_prev      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_read_pos <= n_read_pos;
            r_load_pos <= n_load_pos;
            r_s1_valid <= in_xfer;
            if (r_s1_valid) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_go) begin
                // A load restarts the feedback from silence.
                r_prev <= (r_s2_op == OP_SAMPLE) ? s2_result : '0;
            end
            if (s2_go && (r_s2_op == OP_SAMPLE)) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_op    <= t_op'(i_item.op);
            r_s1_addr  <= acc_addr;
            r_s1_load  <= i_item.load_value;
            r_fwd_hit  <= s2_go && (r_s2_addr == acc_addr);
            r_fwd_data <= wb_data;
        end
        if (r_s1_valid) begin
            r_s2_op   <= r_s1_op;
            r_s2_addr <= r_s1_addr;
            r_s2_load <= r_s1_load;
        end
        if (s2_go && (r_s2_op == OP_SAMPLE)) begin
            r_out_sample <= s2_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.sample_out = r_out_sample;

    // ---------------- assertions ----------------
    `KSDV_ASSERT_NEXT(a_s1_moves_on, i_clk, i_rst_n, r_s1_valid, r_s2_valid, "stage 1 item did not reach stage 2")
    `KSDV_ASSERT_IMPLIES(a_s2_stall_cause, i_clk, i_rst_n, r_s2_valid && !s2_go, r_out_valid && !in_ready, "stage 2 stalled without a full output or with input open")
    `KSDV_ASSERT_NEXT(a_sample_reaches_out, i_clk, i_rst_n, s2_go && (r_s2_op == OP_SAMPLE), r_out_valid, "finished sample not presented at output")

endmodule

[tb/karplus_strong_drum_voice_checker.sv]
// Scoreboard for the drum voice: mirrors register writes and accepted items, predicts
// each output sample and compares it with what the block delivers.
// Depends on ksdv_pkg and the channel interfaces in ksdv_if.sv.
module karplus_strong_drum_voice_checker import ksdv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ksdv_in_if                    i_item_mon,
    ksdv_out_if                   i_result_mon,
    input  logic                  i_drain_done,
    output int                    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_MAX    = 1024;
    localparam int          MIN_RING    = 2;
    localparam logic [15:0] UNITY_GAIN  = 16'd32768;
    localparam logic [15:0] SIGN_POLY   = 16'hB400;
    localparam logic [15:0] BOOT_SEED   = 16'd44257;
    localparam logic [6:0]  BOOT_PCT    = 7'd50;
    localparam logic [10:0] BOOT_LENGTH = 11'd100;
    localparam longint      ROUND_HALF  = 32768;   // half an LSB of the result, in the Q2.15 * Q1.15 product
    localparam int          DRAW_RANGE  = 100;
    localparam longint      SAMPLE_MAX  = 32767;
    localparam longint      SAMPLE_MIN  = -32768;

    logic signed [15:0] wave_ring [RING_MAX];
    logic [9:0]         read_idx;
    logic [9:0]         load_idx;
    logic signed [15:0] last_sample;
    logic [15:0]        sign_state;
    logic [15:0]        gain_setting;
    logic [6:0]         percent_setting;
    logic [10:0]        length_setting;

    logic signed [15:0] expected_samples [$];
    int                 mismatch_count = 0;
    bit                 drain_checked  = 1'b0;

    assign o_errors = mismatch_count;

    function automatic int active_length();
        if (length_setting < MIN_RING) return MIN_RING;
        if (length_setting > RING_MAX) return RING_MAX;
        return int'(length_setting);
    endfunction

    // Pluck one sample: average entry with the last output, apply loss, draw the sign.
    function automatic logic signed [15:0] next_drum_sample();
        int     len;
        int     r;
        longint g;
        longint acc;
        longint val;
        bit     keep_sign;
        len = active_length();
        r   = (int'(read_idx) >= len) ? 0 : int'(read_idx);
        g   = (gain_setting > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(gain_setting);
        acc = (longint'(wave_ring[r]) + longint'(last_sample)) * g;
        val = (acc + ROUND_HALF) >>> 16;
        sign_state = sign_state[0] ? ((sign_state >> 1) ^ SIGN_POLY) : (sign_state >> 1);
        keep_sign  = (int'(sign_state) % DRAW_RANGE) < int'(percent_setting);
        if (!keep_sign) val = -val;
        if (val > SAMPLE_MAX) val = SAMPLE_MAX;
        else if (val < SAMPLE_MIN) val = SAMPLE_MIN;
        wave_ring[r] = 16'(val);
        last_sample  = 16'(val);
        r++;
        if (r >= len) r = 0;
        read_idx = 10'(r);
        return 16'(val);
    endfunction

    always @(posedge i_clk) begin
        int                 len;
        int                 p;
        logic signed [15:0] want;
        if (!i_rst_n) begin
            read_idx        = '0;
            load_idx        = '0;
            last_sample     = '0;
            gain_setting    = UNITY_GAIN;
            percent_setting = BOOT_PCT;
            length_setting  = BOOT_LENGTH;
            sign_state      = BOOT_SEED;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DECAY_GAIN:    gain_setting    = i_cfg_data;
                    REG_PLUS_PERCENT:  percent_setting = i_cfg_data[6:0];
                    REG_PERIOD_LENGTH: length_setting  = i_cfg_data[10:0];
                    REG_NOISE_SEED:    sign_state = (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end

            if (i_item_mon.valid && i_item_mon.ready) begin
                if (i_item_mon.op == OP_LOAD) begin
                    len = active_length();
                    p   = (int'(load_idx) >= len) ? 0 : int'(load_idx);
                    wave_ring[p] = i_item_mon.load_value;
                    p++;
                    if (p >= len) p = 0;
                    load_idx    = 10'(p);
                    read_idx    = '0;
                    last_sample = '0;
                end else begin
                    want = next_drum_sample();
                    expected_samples = {expected_samples, want};
                end
            end

            if (i_result_mon.valid && i_result_mon.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: expected none, actual %0d", i_result_mon.sample_out);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_result_mon.sample_out !== want) begin
                        $error("sample_out: expected %0d, actual %0d",
                               want, i_result_mon.sample_out);
                        mismatch_count++;
                    end
                end
            end

            if (i_drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (expected_samples.size() != 0) begin
                    $error("sample_out: %0d expected samples never arrived",
                           expected_samples.size());
                    mismatch_count += expected_samples.size();
                end
            end
        end
    end

endmodule

[tb/karplus_strong_drum_voice_tb.sv]
// Top of the drum voice testbench: clock, reset, register writes and item traffic,
// with random idling on both channels; the checker beside the block does the scoring.
// Depends on ksdv_pkg, ksdv_if.sv, the block and karplus_strong_drum_voice_checker.
module karplus_strong_drum_voice_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksdv_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int MAX_WAIT      = 14;
    localparam int SETTLE_CYCLES = 6;     // lets a trailing load through the pipeline, plus margin
    localparam int QUIET_LIMIT   = 2000;
    localparam int RING_MAX      = 1024;
    localparam int SMALL_RING    = 48;    // rings up to this size get filled completely

    // Indexes past the last register; writes there must do nothing.
    localparam t_cfg_idx REG_SPARE_LO = 3'd4;
    localparam t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam logic signed [15:0] FULL_POS = 16'sh7FFF;
    localparam logic signed [15:0] FULL_NEG = 16'sh8000;
    localparam logic signed [15:0] ZERO_VAL = 16'sh0000;
    localparam logic signed [15:0] MINUS_ONE = 16'shFFFF;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_index = REG_DECAY_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  drain_done = 1'b0;
    int                    checker_errors;

    ksdv_in_if  #(.SAMPLE_WIDTH(16)) item_ch ();
    ksdv_out_if #(.SAMPLE_WIDTH(16)) result_ch ();

    // Stimulus-side bookkeeping: which table entries hold data and where the block's
    // read and load slots stand, so that a sample never reads an unwritten entry.
    bit          written [RING_MAX];
    int          load_slot = 0;
    int          read_slot = 0;
    logic [10:0] length_reg = PLEN_RESET;

    int sent_loads   = 0;
    int sent_samples = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int quiet_cycles = 0;
    bit src_gaps     = 1'b0;
    bit sink_gaps    = 1'b0;

    karplus_strong_drum_voice uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    karplus_strong_drum_voice_checker scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item_mon  (item_ch),
        .i_result_mon(result_ch),
        .i_drain_done(drain_done),
        .o_errors    (checker_errors)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: ready drops for a random hold before each transfer when stalls are on.
    initial begin
        int hold;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = sink_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold > 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            results_seen++;
            @(negedge i_clk);
        end
    end

    function automatic int ring_len();
        if (length_reg < PLEN_MIN) return int'(PLEN_MIN);
        if (length_reg > RING_MAX) return RING_MAX;
        return int'(length_reg);
    endfunction

    // True when the entry the next sample reads has been loaded at some point.
    function automatic bit entry_loaded();
        int r;
        r = (read_slot >= ring_len()) ? 0 : read_slot;
        return written[r];
    endfunction

    // One item on the input channel. Valid stays high across back-to-back transfers;
    // it only drops when a gap is drawn or when settle() idles the channel.
    task automatic send_item(input t_op kind, input logic signed [15:0] value);
        int gap;
        gap = src_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= kind;
        item_ch.load_value <= value;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic load_item(input logic signed [15:0] value);
        int len;
        int p;
        len = ring_len();
        p   = (load_slot >= len) ? 0 : load_slot;
        written[p] = 1'b1;
        load_slot  = (p + 1 >= len) ? 0 : p + 1;
        read_slot  = 0;
        sent_loads++;
        send_item(OP_LOAD, value);
    endtask

    // load_value rides along with random bits; the block must ignore it here.
    task automatic sample_item();
        int len;
        int r;
        len = ring_len();
        r   = (read_slot >= len) ? 0 : read_slot;
        read_slot = (r + 1 >= len) ? 0 : r + 1;
        sent_samples++;
        send_item(OP_SAMPLE, 16'($urandom));
    endtask

    // Register write; the caller drops the write enable after the last one of a batch.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_PERIOD_LENGTH) length_reg = data[10:0];
        reg_writes++;
        @(negedge i_clk);
    endtask

    // Wait until every sample has come back, then let a trailing load drain.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (results_seen != sent_samples) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0]        gain;
        logic [15:0]        pct;
        logic [15:0]        plen;
        logic signed [15:0] value;
        int                 len;
        int                 fill;
        int                 burst;
        int                 style;

        item_ch.valid      = 1'b0;
        item_ch.op         = OP_LOAD;
        item_ch.load_value = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- Directed part ----
        // Spare register indexes, then a two-entry ring from a length below the minimum,
        // gain above one, a percent that always keeps the sign and a zero seed.
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        write_reg(REG_PERIOD_LENGTH, 16'd0);
        write_reg(REG_DECAY_GAIN, 16'hFFFF);
        write_reg(REG_PLUS_PERCENT, 16'd127);
        write_reg(REG_NOISE_SEED, 16'd0);
        cfg_we <= 1'b0;
        load_item(FULL_POS);
        load_item(FULL_NEG);
        repeat (3) sample_item();       // read slot wraps around the short ring
        load_item(ZERO_VAL);            // load slot wrapped; clears read slot and history
        sample_item();

        // Oversized length acts as the full table; always negate, tiny gain.
        settle();
        write_reg(REG_PERIOD_LENGTH, 16'd2047);
        write_reg(REG_PLUS_PERCENT, 16'd0);
        write_reg(REG_DECAY_GAIN, 16'd1);
        cfg_we <= 1'b0;
        repeat (4) load_item(16'($urandom));
        repeat (3) sample_item();

        // Shrink the ring under both slots: they fall back to entry 0. Zero gain.
        settle();
        write_reg(REG_PERIOD_LENGTH, 16'd1);
        write_reg(REG_DECAY_GAIN, 16'd0);
        write_reg(REG_NOISE_SEED, 16'hFFFF);
        cfg_we <= 1'b0;
        sample_item();
        load_item(FULL_NEG);
        repeat (2) sample_item();

        // Unity gain on full-scale entries of both signs, sign always kept.
        settle();
        write_reg(REG_PERIOD_LENGTH, 16'd3);
        write_reg(REG_DECAY_GAIN, GAIN_ONE);
        write_reg(REG_PLUS_PERCENT, 16'd100);
        cfg_we <= 1'b0;
        load_item(FULL_POS);
        load_item(FULL_POS);
        load_item(FULL_NEG);
        repeat (3) sample_item();

        // ---- Random part ----
        // Each phase picks new settings while idle, then plays a few plucks: fill the
        // ring with noise, run samples around it, and sometimes throw in stray items.
        while (sent_loads + sent_samples < ITEM_TARGET) begin
            settle();
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 5))
                0:       gain = 16'd0;
                1:       gain = GAIN_ONE;
                2:       gain = 16'($urandom_range(32769, 65535));
                3:       gain = 16'($urandom_range(0, 32768));
                default: gain = 16'($urandom_range(24576, 32768));
            endcase
            case ($urandom_range(0, 5))
                0:       pct = 16'd0;
                1:       pct = 16'd100;
                2:       pct = 16'($urandom_range(101, 127));
                default: pct = 16'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 9))
                0:       plen = 16'($urandom_range(0, 1));
                1:       plen = 16'($urandom_range(41, 1024));
                2:       plen = ($urandom_range(0, 1) != 0) ? 16'd1024
                                                            : 16'($urandom_range(1025, 2047));
                default: plen = 16'($urandom_range(2, 40));
            endcase
            // Bits above each register's width go out random and must be dropped.
            write_reg(REG_DECAY_GAIN, gain);
            write_reg(REG_PLUS_PERCENT, {9'($urandom), pct[6:0]});
            write_reg(REG_PERIOD_LENGTH, {5'($urandom), plen[10:0]});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NOISE_SEED, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(t_cfg_idx'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          16'($urandom));
            cfg_we <= 1'b0;

            repeat ($urandom_range(1, 3)) begin
                len   = ring_len();
                fill  = (len <= SMALL_RING) ? len + $urandom_range(0, 2)
                                            : $urandom_range(8, SMALL_RING);
                style = $urandom_range(0, 7);
                repeat (fill) begin
                    if (style == 0) begin
                        case ($urandom_range(0, 3))
                            0:       value = FULL_POS;
                            1:       value = FULL_NEG;
                            2:       value = ZERO_VAL;
                            default: value = MINUS_ONE;
                        endcase
                    end else begin
                        value = 16'($urandom);
                    end
                    load_item(value);
                end
                burst = $urandom_range(1, 3 * ((len < SMALL_RING) ? len : SMALL_RING));
                repeat (burst) if (entry_loaded()) sample_item();
                // Stray traffic: loads that cut a note short and isolated samples.
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 1) != 0 && entry_loaded()) sample_item();
                        else load_item(16'($urandom));
                    end
                end
            end
        end

        // ---- Drain and verdict ----
        settle();
        drain_done <= 1'b1;
        repeat (2) @(negedge i_clk);
        $display("Run covered %0d loads and %0d samples under %0d register writes,",
                 sent_loads, sent_samples, reg_writes);
        $display("with %0d output samples compared against the prediction.", results_seen);
        if (checker_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
